[hw/rtl/bilinear_rggb_debayer_defines.svh]
// ----------------------------------------------------------------------------
// bilinear rggb debayer assertion macros
// shared assertion shorthands for the debayer checker
// ----------------------------------------------------------------------------
`ifndef BILINEAR_RGGB_DEBAYER_DEFINES_SVH
`define BILINEAR_RGGB_DEBAYER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("debayer assertion failed");

// next-cycle implication, disabled while in reset
`define BRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("debayer assertion failed");

`endif

[hw/rtl/brd_pkg.sv]
// ----------------------------------------------------------------------------
// brd_pkg
// shared constants and types of the bilinear rggb debayer
// ----------------------------------------------------------------------------
package brd_pkg;

  // frame limits
  localparam int MAX_ROW_SAMPLES = 2048;
  localparam int MAX_ROWS        = 2048;
  localparam int MIN_DIM         = 3;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 12;
  localparam int PITCH_W  = 13;
  localparam int COLOR_W  = 24;
  localparam int IDX_W    = 24;
  localparam int CHAN_W   = 8;

  // position widths
  localparam int COL_W    = $clog2(MAX_ROW_SAMPLES);
  localparam int ROWLEN_W = $clog2(MAX_ROW_SAMPLES + 1);
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);

  // line memory holds both stored rows of one column
  localparam int LINE_W = 2 * SAMPLE_W;

  // register reset values
  localparam logic [CFG_W-1:0]   RST_ACTIVE_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0]   RST_ACTIVE_HEIGHT = CFG_W'(480);
  localparam logic [CFG_W-1:0]   RST_ROW_SAMPLES   = CFG_W'(640);
  localparam logic [PITCH_W-1:0] RST_OUTPUT_PITCH  = PITCH_W'(640);

  // register indexes
  typedef enum logic [1:0] {
    CFG_ACTIVE_WIDTH  = 2'd0,
    CFG_ACTIVE_HEIGHT = 2'd1,
    CFG_ROW_SAMPLES   = 2'd2,
    CFG_OUTPUT_PITCH  = 2'd3
  } brd_cfg_e;

  // 3x3 neighbourhood, p[row][col], col 2 newest
  typedef struct packed {
    logic [2:0][2:0][SAMPLE_W-1:0] p;
    logic                          x_odd;
    logic                          y_odd;
  } brd_win_t;

endpackage

[hw/rtl/brd_ram.sv]
// ----------------------------------------------------------------------------
// brd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/brd_interp.sv]
// ----------------------------------------------------------------------------
// brd_interp
// bilinear colour reconstruction of one site from its 3x3 neighbourhood
// ----------------------------------------------------------------------------
module brd_interp (
  input  brd_pkg::brd_win_t                win_i,
  output logic [brd_pkg::COLOR_W-1:0]      color_o
);

  localparam int SW = brd_pkg::SAMPLE_W;

  // drop two bits and saturate to one byte
  function automatic logic [brd_pkg::CHAN_W-1:0] to_byte(input logic [SW-1:0] v);
    logic [SW-3:0] sh;
    sh = v[SW-1:2];
    if (sh > (SW-2)'(255)) begin
      return brd_pkg::CHAN_W'(255);
    end
    return sh[brd_pkg::CHAN_W-1:0];
  endfunction

  logic [SW+1:0] cross_sum, diag_sum;
  logic [SW:0]   horiz_sum, vert_sum;
  logic [SW-1:0] cross_avg, diag_avg, horiz_avg, vert_avg, cen;
  logic [SW-1:0] red, grn, blu;

  // neighbour sums
  assign cross_sum = {2'b00, win_i.p[1][0]} + {2'b00, win_i.p[1][2]}
                   + {2'b00, win_i.p[0][1]} + {2'b00, win_i.p[2][1]};
  assign diag_sum  = {2'b00, win_i.p[0][0]} + {2'b00, win_i.p[0][2]}
                   + {2'b00, win_i.p[2][0]} + {2'b00, win_i.p[2][2]};
  assign horiz_sum = {1'b0, win_i.p[1][0]} + {1'b0, win_i.p[1][2]};
  assign vert_sum  = {1'b0, win_i.p[0][1]} + {1'b0, win_i.p[2][1]};

  assign cross_avg = cross_sum[SW+1:2];
  assign diag_avg  = diag_sum[SW+1:2];
  assign horiz_avg = horiz_sum[SW:1];
  assign vert_avg  = vert_sum[SW:1];
  assign cen       = win_i.p[1][1];

  // pick by bayer phase
  always_comb begin
    case ({win_i.y_odd, win_i.x_odd})
      2'b00: begin
        red = cen;       grn = cross_avg; blu = diag_avg;
      end
      2'b01: begin
        red = horiz_avg; grn = cen;       blu = vert_avg;
      end
      2'b10: begin
        red = vert_avg;  grn = cen;       blu = horiz_avg;
      end
      default: begin
        red = diag_avg;  grn = cross_avg; blu = cen;
      end
    endcase
  end

  assign color_o = {to_byte(red), to_byte(grn), to_byte(blu)};

endmodule

[hw/rtl/bilinear_rggb_debayer.sv]
// ----------------------------------------------------------------------------
// bilinear_rggb_debayer
// streaming bilinear demosaic of an rggb bayer stream into packed rgb pixels
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// in        sink       in_valid_i / in_stall_o    sample_i, frame_start_i
// out       source     out_valid_o / out_stall_i  packed_color_o, out_index_o,
//                                                 last_of_frame_o
// cfg       sink       cfg_we_i                   cfg_index_i, cfg_data_i
//
// one sample a cycle sustained, set by one read-modify-write of the line
// memory per sample; a write to the column being read is forwarded.
// the request completing a window leaves via the read and output registers.
// reset clears positions, window and registers; line memory is not cleared.
// an output stall holds one request in the read stage, then stalls the input.
// ----------------------------------------------------------------------------
module bilinear_rggb_debayer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [brd_pkg::PITCH_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [brd_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [brd_pkg::COLOR_W-1:0]     packed_color_o,
  output logic [brd_pkg::IDX_W-1:0]       out_index_o,
  output logic                            last_of_frame_o
);

  localparam int SW    = brd_pkg::SAMPLE_W;
  localparam int CW    = brd_pkg::COL_W;
  localparam int LW    = brd_pkg::ROWLEN_W;
  localparam int RW    = brd_pkg::ROWS_W;
  localparam int CFW   = brd_pkg::CFG_W;
  localparam int PW    = brd_pkg::PITCH_W;

  // configuration registers
  logic [CFW-1:0] width_q, height_q, row_samples_q;
  logic [PW-1:0]  pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= brd_pkg::RST_ACTIVE_WIDTH;
      height_q      <= brd_pkg::RST_ACTIVE_HEIGHT;
      row_samples_q <= brd_pkg::RST_ROW_SAMPLES;
      pitch_q       <= brd_pkg::RST_OUTPUT_PITCH;
    end else if (cfg_we_i) begin
      case (brd_pkg::brd_cfg_e'(cfg_index_i))
        brd_pkg::CFG_ACTIVE_WIDTH:  width_q       <= cfg_data_i[CFW-1:0];
        brd_pkg::CFG_ACTIVE_HEIGHT: height_q      <= cfg_data_i[CFW-1:0];
        brd_pkg::CFG_ROW_SAMPLES:   row_samples_q <= cfg_data_i[CFW-1:0];
        brd_pkg::CFG_OUTPUT_PITCH:  pitch_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped frame geometry
  logic [LW-1:0] w, rs;
  logic [RW-1:0] h;

  always_comb begin
    if (width_q < CFW'(brd_pkg::MIN_DIM)) begin
      w = LW'(brd_pkg::MIN_DIM);
    end else if (width_q > brd_pkg::MAX_ROW_SAMPLES) begin
      w = LW'(brd_pkg::MAX_ROW_SAMPLES);
    end else begin
      w = LW'(width_q);
    end
    if (height_q < CFW'(brd_pkg::MIN_DIM)) begin
      h = RW'(brd_pkg::MIN_DIM);
    end else if (height_q > brd_pkg::MAX_ROWS) begin
      h = RW'(brd_pkg::MAX_ROWS);
    end else begin
      h = RW'(height_q);
    end
    if (row_samples_q < w) begin
      rs = w;
    end else if (row_samples_q > brd_pkg::MAX_ROW_SAMPLES) begin
      rs = LW'(brd_pkg::MAX_ROW_SAMPLES);
    end else begin
      rs = LW'(row_samples_q);
    end
  end

  // pipeline control
  logic in_accept, s1_fire, out_free;
  logic s1_valid_q;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // position of the incoming sample
  logic [CW-1:0] col_q, cur_c, col_d;
  logic [RW-1:0] row_q, cur_r, row_d;
  logic [CW:0]   c_inc;
  logic          in_rows, act, emit, last;

  assign cur_c   = frame_start_i ? '0 : col_q;
  assign cur_r   = frame_start_i ? '0 : row_q;
  assign in_rows = cur_r < h;
  assign act     = in_rows && (LW'(cur_c) < w);
  assign emit    = act && (cur_r >= RW'(2)) && (cur_c >= CW'(2));
  assign last    = (LW'(cur_c) == w - LW'(1)) && (cur_r == h - RW'(1));
  assign c_inc   = {1'b0, cur_c} + (CW+1)'(1);

  always_comb begin
    col_d = cur_c;
    row_d = cur_r;
    if (in_rows) begin
      if (LW'(c_inc) >= rs) begin
        col_d = '0;
        row_d = cur_r + RW'(1);
      end else begin
        col_d = c_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line memory: older row in the upper half, newer row in the lower half
  logic [2*SW-1:0] rd_data, wr_data;
  logic [SW-1:0]   top, mid;
  logic            wr_en, fwd_hit;

  logic            s1_act_q, s1_emit_q, s1_last_q, fwd_q;
  logic [CW-1:0]   s1_col_q, s1_x_q;
  logic [RW-1:0]   s1_y_q;
  logic [SW-1:0]   s1_sample_q, fwd_older_q, fwd_newer_q;

  assign top     = fwd_q ? fwd_older_q : rd_data[2*SW-1:SW];
  assign mid     = fwd_q ? fwd_newer_q : rd_data[SW-1:0];
  assign wr_en   = s1_fire && s1_act_q;
  assign wr_data = {mid, s1_sample_q};
  assign fwd_hit = wr_en && (cur_c == s1_col_q);

  brd_ram #(
    .WIDTH (brd_pkg::LINE_W),
    .DEPTH (brd_pkg::MAX_ROW_SAMPLES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (in_accept && act),
    .raddr_i (cur_c),
    .rdata_o (rd_data)
  );

  // read stage: request waits here for the memory data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_act_q    <= act;
      s1_emit_q   <= emit;
      s1_last_q   <= last;
      s1_col_q    <= cur_c;
      s1_x_q      <= cur_c - CW'(1);
      s1_y_q      <= cur_r - RW'(1);
      s1_sample_q <= sample_i;
      fwd_q       <= fwd_hit;
      fwd_older_q <= mid;
      fwd_newer_q <= s1_sample_q;
    end
  end

  // window columns, two older columns of three rows
  logic [5:0][SW-1:0] wc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= '0;
    end else if (wr_en) begin
      wc_q[0] <= wc_q[3];
      wc_q[1] <= wc_q[4];
      wc_q[2] <= wc_q[5];
      wc_q[3] <= top;
      wc_q[4] <= mid;
      wc_q[5] <= s1_sample_q;
    end
  end

  // neighbourhood and colour
  brd_pkg::brd_win_t           win;
  logic [brd_pkg::COLOR_W-1:0] color;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win.p[k][0] = wc_q[k];
      win.p[k][1] = wc_q[3+k];
    end
    win.p[0][2] = top;
    win.p[1][2] = mid;
    win.p[2][2] = s1_sample_q;
    win.x_odd   = s1_x_q[0];
    win.y_odd   = s1_y_q[0];
  end

  brd_interp u_interp (
    .win_i   (win),
    .color_o (color)
  );

  // output word index
  logic [RW+PW-1:0]          prod;
  logic [brd_pkg::IDX_W-1:0] index;

  assign prod  = s1_y_q * pitch_q;
  assign index = brd_pkg::IDX_W'(prod) + brd_pkg::IDX_W'(s1_x_q);

  // output register
  logic                        out_valid_q, out_last_q;
  logic [brd_pkg::COLOR_W-1:0] out_color_q;
  logic [brd_pkg::IDX_W-1:0]   out_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      out_color_q <= color;
      out_index_q <= index;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packed_color_o  = out_color_q;
  assign out_index_o     = out_index_q;
  assign last_of_frame_o = out_last_q;

endmodule

[hw/rtl/brd_checker.sv]
// ----------------------------------------------------------------------------
// brd_checker
// port-level checks of the debayer handshakes and pipeline timing
// ----------------------------------------------------------------------------
`include "bilinear_rggb_debayer_defines.svh"

module brd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic [brd_pkg::COLOR_W-1:0]     packed_color_o,
  input  logic [brd_pkg::IDX_W-1:0]       out_index_o,
  input  logic                            last_of_frame_o
);

  // input only stalls behind a stalled result
  `BRD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // a fresh result follows an accepted request through the read stage and output register
  `BRD_ASSERT_IMP(a_result_latency, clk_i, rst_ni, $rose(out_valid_o),
                  $past(in_valid_i && !in_stall_o, 2))

  // a stalled result stays offered
  `BRD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its payload
  `BRD_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
                  $stable(packed_color_o) && $stable(out_index_o) && $stable(last_of_frame_o))

endmodule

bind bilinear_rggb_debayer brd_checker u_brd_checker (.*);
